/* hw/rtl/deq_pkg.sv */
// deq_pkg: shared constants and types for the double-ended queue
// depends on nothing; imported by deq_idx_unit and double_ended_queue
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 8;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LIST_FWD   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_LIST_BWD   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             dec;
    } t_idx_op;

endpackage

/* hw/rtl/deq_ram.sv */
// deq_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/deq_idx_unit.sv */
// deq_idx_unit: shared circular index step unit, wrap increment or decrement
// depends on deq_pkg
module deq_idx_unit import deq_pkg::*; (
    input  t_idx_op          i_op,
    output logic [IDX_W-1:0] o_idx
);
    always_comb begin
        if (i_op.dec) begin
            o_idx = (i_op.idx == '0) ? IDX_W'(DEPTH - 1) : i_op.idx - IDX_W'(1);
        end else begin
            o_idx = (i_op.idx == IDX_W'(DEPTH - 1)) ? '0 : i_op.idx + IDX_W'(1);
        end
    end
endmodule

/* hw/rtl/double_ended_queue.sv */
// double_ended_queue: deque of bytes in a circular RAM under a small sequencer
// depends on deq_pkg, deq_ram, deq_idx_unit
// push and pop give their single result beat in the cycle after accept
// list: each stored element takes a RAM read state, then an output beat, DEPTH at most
// ready returns the cycle after the last result beat is taken; one item at a time
// reset: synchronous active low, empties the deque; RAM contents are not cleared
module double_ended_queue import deq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_item_value,
    output logic [STAT_W-1:0] o_status,
    output logic              o_last
);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_SEND} t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_front, n_front;
    logic [IDX_W-1:0]  r_back, n_back;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_dir_bwd, n_dir_bwd;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_last, n_last;
    logic              r_from_ram, n_from_ram;

    t_idx_op           idx_op;
    logic [IDX_W-1:0]  idx_res;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;
    logic              in_beat;
    logic              out_beat;
    logic              full;
    logic              empty;

    assign in_beat  = i_valid && o_ready;
    assign out_beat = o_valid && i_ready;
    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);

    // operand select for the shared index unit
    always_comb begin
        idx_op.idx = r_pos;
        idx_op.dec = r_dir_bwd;
        if (r_state == S_IDLE) begin
            case (i_func)
                FN_PUSH_FRONT: begin
                    idx_op.idx = r_front;
                    idx_op.dec = 1'b1;
                end
                FN_POP_FRONT: begin
                    idx_op.idx = r_front;
                    idx_op.dec = 1'b0;
                end
                FN_PUSH_BACK: begin
                    idx_op.idx = r_back;
                    idx_op.dec = 1'b0;
                end
                FN_POP_BACK, FN_LIST_BWD: begin
                    idx_op.idx = r_back;
                    idx_op.dec = 1'b1;
                end
                default: begin
                    idx_op.idx = r_front;
                    idx_op.dec = 1'b0;
                end
            endcase
        end
    end

    deq_idx_unit u_idx (
        .i_op  (idx_op),
        .o_idx (idx_res)
    );

    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_back     = r_back;
        n_count    = r_count;
        n_pos      = r_pos;
        n_left     = r_left;
        n_dir_bwd  = r_dir_bwd;
        n_status   = r_status;
        n_last     = r_last;
        n_from_ram = r_from_ram;
        ram_we     = 1'b0;
        ram_waddr  = r_back;
        ram_re     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_status   = ST_OK;
                    n_last     = 1'b1;
                    n_from_ram = 1'b0;
                    case (i_func)
                        FN_PUSH_FRONT, FN_PUSH_BACK: begin
                            n_state = S_SEND;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (i_func == FN_PUSH_FRONT) begin
                                    ram_waddr = idx_res;
                                    n_front   = idx_res;
                                end else begin
                                    ram_waddr = r_back;
                                    n_back    = idx_res;
                                end
                            end
                        end
                        FN_POP_FRONT, FN_POP_BACK: begin
                            n_state = S_SEND;
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                if (i_func == FN_POP_FRONT) begin
                                    n_front = idx_res;
                                end else begin
                                    n_back = idx_res;
                                end
                            end
                        end
                        FN_LIST_FWD, FN_LIST_BWD: begin
                            if (empty) begin
                                n_state  = S_SEND;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state   = S_READ;
                                n_left    = r_count;
                                n_dir_bwd = (i_func == FN_LIST_BWD);
                                n_pos     = (i_func == FN_LIST_BWD) ? idx_res : r_front;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                ram_re     = 1'b1;
                n_state    = S_SEND;
                n_status   = ST_OK;
                n_from_ram = 1'b1;
                n_last     = (r_left == CNT_W'(1));
            end
            S_SEND: begin
                if (out_beat) begin
                    if (r_from_ram && !r_last) begin
                        n_state = S_READ;
                        n_pos   = idx_res;
                        n_left  = r_left - CNT_W'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_front    <= '0;
            r_back     <= '0;
            r_count    <= '0;
            r_left     <= '0;
            r_dir_bwd  <= 1'b0;
            r_last     <= 1'b0;
            r_from_ram <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_front    <= n_front;
            r_back     <= n_back;
            r_count    <= n_count;
            r_left     <= n_left;
            r_dir_bwd  <= n_dir_bwd;
            r_last     <= n_last;
            r_from_ram <= n_from_ram;
        end
        r_pos    <= n_pos;
        r_status <= n_status;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_SEND);
    assign o_item_value = r_from_ram ? ram_rdata : '0;
    assign o_status     = r_status;
    assign o_last       = r_last;
endmodule
